FILE: hdl/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
package bsa_pkg;

  localparam int DEF_MAX_SLOTS = 1024;
  localparam int DEF_WORD_BITS = 32;

  localparam int CAP_W   = 11;
  localparam int BLOCK_W = 21;
  localparam int SLOT_W  = 10;
  localparam int OFFS_W  = 30;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CAP_W-1:0]   CAP_RESET   = 11'd1024;
  localparam logic [BLOCK_W-1:0] BLOCK_RESET = 21'd4096;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic REG_SLOT_CAPACITY = 1'b0;
  localparam logic REG_BLOCK_BYTES   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_BADREL = 2'd2
  } bsa_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } bsa_state_t;

  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] slot_index;
  } bsa_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [OFFS_W-1:0] byte_offset;
  } bsa_rsp_t;

  // result handed from the scan engine to the output stage
  typedef struct packed {
    logic        valid;
    bsa_status_t status;
  } bsa_res_t;

endpackage

FILE: hdl/bsa_ram.sv
// Generic single-port-write, registered-read RAM.
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/bsa_scan.sv
// Free-map scan engine: clearing pass, first-fit search, release and write-back.
module bsa_scan import bsa_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS,
  parameter int WORD_BITS = DEF_WORD_BITS,
  localparam int NWORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS,
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1,
  localparam int SW     = $clog2(MAX_SLOTS),
  localparam int CAPW   = $clog2(MAX_SLOTS + 1),
  localparam int BW     = ((CAPW > CAP_W) ? CAPW : CAP_W) + 1,
  localparam int WBW    = $clog2(WORD_BITS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  bsa_req_t         req,
  input  logic [CAP_W-1:0] slot_capacity,
  output bsa_res_t         res,
  input  logic             res_ready,
  output logic [SW-1:0]    res_slot
);

  bsa_state_t state, state_next;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [AW-1:0] clr_addr;
  logic [AW:0]   rd_w;
  logic [BW-1:0] rd_base;
  logic          chk_valid;
  logic [AW-1:0] chk_w;
  logic [BW-1:0] chk_base;
  logic          mode;
  logic [SLOT_W-1:0] idx;
  logic [BW-1:0] hw;
  bsa_status_t   res_status;

  logic [BW-1:0]        cap_ext, cap_sat, rem, idx_ext, diff;
  logic [WORD_BITS-1:0] avail, onehot;
  logic [WBW-1:0]       pos, bit_sel;
  logic                 any_free, rel_hit, fin;
  bsa_status_t          fin_status;
  logic [BW-1:0]        fin_slot;
  logic                 accept;

  bsa_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_w[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign cap_ext = BW'(slot_capacity);
  assign cap_sat = (cap_ext > BW'(MAX_SLOTS)) ? BW'(MAX_SLOTS) : cap_ext;
  assign rem     = cap_sat - chk_base;
  assign idx_ext = BW'(idx);
  assign diff    = idx_ext - chk_base;
  assign rel_hit = (idx_ext >= chk_base) && (diff < BW'(WORD_BITS));

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      avail[j] = ram_rdata[j] && (BW'(j) < rem);
    end
  end

  always_comb begin
    pos = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        pos = WBW'(j);
      end
    end
  end

  assign any_free = |avail;
  assign bit_sel  = (mode == MODE_ALLOC) ? pos : diff[WBW-1:0];
  assign onehot   = WORD_BITS'(1) << bit_sel;
  assign accept   = req_valid && req_ready;

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = chk_w;
    ram_wdata  = ram_rdata;
    fin        = 1'b0;
    fin_status = STATUS_OK;
    fin_slot   = '0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '1;
        if (clr_addr == AW'(NWORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req.mode == MODE_RELEASE && !(BW'(req.slot_index) < hw)) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (chk_valid) begin
          if (mode == MODE_ALLOC) begin
            if (chk_base >= cap_sat) begin
              fin        = 1'b1;
              fin_status = STATUS_FULL;
            end else if (any_free) begin
              fin       = 1'b1;
              fin_slot  = chk_base + BW'(pos);
              ram_we    = 1'b1;
              ram_wdata = ram_rdata & ~onehot;
            end
          end else if (rel_hit) begin
            fin       = 1'b1;
            fin_slot  = idx_ext;
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | onehot;
          end
        end
        if (fin) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      hw       <= '0;
      chk_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == ST_IDLE) begin
        chk_valid <= 1'b0;
      end else if (state == ST_SCAN) begin
        chk_valid <= 1'b1;
      end
      if (state == ST_SCAN && fin && mode == MODE_ALLOC && fin_status == STATUS_OK &&
          fin_slot >= hw) begin
        hw <= fin_slot + BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode       <= req.mode;
      idx        <= req.slot_index;
      rd_w       <= '0;
      rd_base    <= '0;
      res_status <= STATUS_BADREL;
      res_slot   <= '0;
    end else if (state == ST_SCAN) begin
      rd_w     <= rd_w + (AW+1)'(1);
      rd_base  <= rd_base + BW'(WORD_BITS);
      chk_w    <= rd_w[AW-1:0];
      chk_base <= rd_base;
      if (fin) begin
        res_status <= fin_status;
        res_slot   <= fin_slot[SW-1:0];
      end
    end
  end

  assign res.valid  = (state == ST_EMIT);
  assign res.status = res_status;

  property p_hw_bound;
    @(posedge clk) disable iff (rst) hw <= BW'(MAX_SLOTS);
  endproperty
  a_hw_bound: assert property (p_hw_bound) else $error("high-water count above map size");

  property p_alloc_below_hw;
    @(posedge clk) disable iff (rst)
      (res.valid && mode == MODE_ALLOC && res_status == STATUS_OK) |-> (BW'(res_slot) < hw);
  endproperty
  a_alloc_below_hw: assert property (p_alloc_below_hw)
    else $error("allocated slot not below high-water count");

  property p_err_slot_zero;
    @(posedge clk) disable iff (rst)
      (res.valid && res_status != STATUS_OK) |-> (res_slot == '0);
  endproperty
  a_err_slot_zero: assert property (p_err_slot_zero) else $error("error result carries a slot");

  property p_wb_has_data;
    @(posedge clk) disable iff (rst) (state == ST_SCAN && ram_we) |-> chk_valid;
  endproperty
  a_wb_has_data: assert property (p_wb_has_data) else $error("write-back without read data");

  property p_accept_busy;
    @(posedge clk) disable iff (rst) accept |=> !req_ready;
  endproperty
  a_accept_busy: assert property (p_accept_busy) else $error("request taken while busy");

endmodule

FILE: hdl/bitmap_slot_allocator_unit.sv
// Top level of the bitmap slot allocator: APB registers, scan engine, output register.
//
// Requests arrive on req (req_valid/req_ready) and carry a mode and a slot
// index; each request yields exactly one response on rsp (rsp_valid/rsp_ready)
// with status, slot and byte offset (slot * block_bytes, modulo 2^30).
// One request is in work at a time. A scan reads the free map from word 0, one
// word per cycle: an allocate stops at the first word with a free slot below
// the capacity limit or at the limit itself, and a release of slot s stops at
// the word that holds s. A release at or above the high-water count skips it.
// After reset the free map is cleared to all free by a pass over its NWORDS
// words (32 of 32 bits by default), during which req_ready stays low;
// registers are writable throughout. The response sits in an output register:
// a new request is taken while it waits, but a finished result holds in the
// engine until the receiver takes the previous one.
// Registers: slot_capacity at 0x0, block_bytes at 0x4.
module bitmap_slot_allocator_unit import bsa_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS,
  parameter int WORD_BITS = DEF_WORD_BITS,
  localparam int SW = $clog2(MAX_SLOTS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  bsa_req_t           req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output bsa_rsp_t           rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [CAP_W-1:0]   slot_capacity;
  logic [BLOCK_W-1:0] block_bytes;
  bsa_res_t           res;
  logic               res_ready;
  logic [SW-1:0]      res_slot;
  logic [SW+BLOCK_W-1:0] prod;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_capacity <= CAP_RESET;
      block_bytes   <= BLOCK_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_SLOT_CAPACITY: slot_capacity <= pwdata[CAP_W-1:0];
        REG_BLOCK_BYTES:   block_bytes   <= pwdata[BLOCK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SLOT_CAPACITY: prdata = PDATA_W'(slot_capacity);
      REG_BLOCK_BYTES:   prdata = PDATA_W'(block_bytes);
      default:           prdata = '0;
    endcase
  end

  bsa_scan #(.MAX_SLOTS(MAX_SLOTS), .WORD_BITS(WORD_BITS)) u_scan (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .slot_capacity (slot_capacity),
    .res           (res),
    .res_ready     (res_ready),
    .res_slot      (res_slot)
  );

  assign res_ready = !rsp_valid || rsp_ready;
  assign prod      = (SW+BLOCK_W)'(res_slot) * (SW+BLOCK_W)'(block_bytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      rsp.status      <= res.status;
      rsp.slot        <= SLOT_W'(res_slot);
      rsp.byte_offset <= OFFS_W'(prod);
    end
  end

endmodule
